// ----- rtl/cssc_pkg.sv -----
// Shared types and constants for the CSS color to RGB converter.
package cssc_pkg;

  // Opcodes of an input item
  typedef logic [1:0] opcode_t;
  localparam opcode_t OP_RGB = 2'd0;
  localparam opcode_t OP_HSL = 2'd1;
  localparam opcode_t OP_HWB = 2'd2;

  // Fixed-point units: 1/256 percent, 1/256 degree
  localparam logic [14:0] PCT_ONE = 15'd25600;
  localparam logic [15:0] SECTOR  = 16'd15360;

  // Pipeline depth from accept to result strobe
  localparam int unsigned NUM_STAGES = 10;

  // Numerator scaling ahead of the shared divide by 625 * 2^30
  typedef enum logic [1:0] {
    SCL_HSL,
    SCL_HWB,
    SCL_RGB
  } scale_t;

  // Sideband that travels with every item
  typedef struct packed {
    opcode_t     op;
    logic        pct;
    logic        grey;
    logic [12:0] alpha;
    logic [7:0]  rb0;
    logic [7:0]  rb1;
    logic [7:0]  rb2;
  } side_t;

endpackage

// ----- rtl/css_color_to_rgb_converter_top.sv -----
// Top level: CSS rgb/hsl/hwb color to 8-bit RGB plus clamped alpha.
// Throughput: one item per cycle; busy is never raised, every stage advances each cycle.
// The grey case of hwb runs an 8-step restoring divider spread over stages 2 to 9.
// Reset (rst_n low, synchronous) clears the stage valid bits; no item is in flight after it.
module css_color_to_rgb_converter_top (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  cssc_pkg::opcode_t      in_opcode,
  input  logic signed [23:0]     in_first_arg,
  input  logic signed [23:0]     in_second_arg,
  input  logic signed [23:0]     in_third_arg,
  input  logic                   in_percent_mode,
  input  logic signed [15:0]     in_alpha_in,
  output logic                   out_strobe,
  output logic [7:0]             out_red_byte,
  output logic [7:0]             out_green_byte,
  output logic [7:0]             out_blue_byte,
  output logic [12:0]            out_alpha_out
);
  import cssc_pkg::*;

  function automatic logic [14:0] clamp_pct(input logic signed [23:0] a);
    logic [14:0] v;
    if (a < 0) v = '0;
    else if (a > 24'sd25600) v = PCT_ONE;
    else v = a[14:0];
    return v;
  endfunction

  // Plain rgb channel: a / 256 clamped, round half to even
  function automatic logic [7:0] rgb_byte(input logic signed [23:0] a);
    logic [7:0] v;
    logic       up;
    up = (a[7:0] > 8'd128) || ((a[7:0] == 8'd128) && a[8]);
    if (a <= 0) v = '0;
    else if (a >= 24'sd65280) v = 8'd255;
    else v = a[15:8] + 8'(up);
    return v;
  endfunction

  // One restoring division step
  function automatic logic [24:0] div_step(input logic [23:0] r, input logic [15:0] s,
                                           input int unsigned sh);
    logic [23:0] d;
    logic [24:0] v;
    d = 24'(s) << sh;
    if (r >= d) v = {1'b1, r - d};
    else v = {1'b0, r};
    return v;
  endfunction

  logic [NUM_STAGES-1:0] vld_r;
  side_t       side_r [0:8];
  side_t       side_nxt;

  logic [14:0] c1_r [0:4];
  logic [14:0] c2_r [0:4];
  logic [14:0] c3_r [0:4];
  logic [14:0] c1_nxt, c2_nxt, c3_nxt;
  logic [15:0] wb_nxt;
  logic [13:0] u_r, u2_r;
  logic [10:0] lo11_r, lo11_2_r;
  logic [14:0] cbase_r;
  logic [7:0]  q45_r;
  logic [27:0] q45_prod;
  logic [29:0] cc_r [0:2];
  logic [13:0] rem45;
  logic [16:0] h_r;
  logic [2:0]  sec_nxt;
  logic [2:0]  sec_r [0:1];
  logic [14:0] hm;
  logic [13:0] x_nxt, x_r;
  logic [15:0] base;
  logic [29:0] mul_a;
  logic [43:0] pa_nxt, pb_nxt, pm_nxt;
  logic [43:0] pa_r, pb_r, pm_r;
  logic [43:0] n_nxt [0:2];
  logic [43:0] n_r [0:2];
  logic [43:0] plc [0:2];
  logic [23:0] gr_r [0:8];
  logic [15:0] gs_r [0:8];
  logic [7:0]  gq_r [0:8];
  logic [7:0]  chan_byte [0:2];
  logic [7:0]  gbyte;
  logic        gup;
  scale_t      sel;
  logic [7:0]  red_nxt, green_nxt, blue_nxt;
  logic [7:0]  red_r, green_r, blue_r;
  logic [12:0] alpha_r;

  assign busy = 1'b0;

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NUM_STAGES-2:0], start};
    end
  end

  // Stage 1: clamps, plain rgb bytes, hue split for mod 360
  always_comb begin
    c1_nxt = clamp_pct(in_first_arg);
    c2_nxt = clamp_pct(in_second_arg);
    c3_nxt = clamp_pct(in_third_arg);
    wb_nxt = 16'(c2_nxt) + 16'(c3_nxt);
    side_nxt.op    = in_opcode;
    side_nxt.pct   = in_percent_mode;
    side_nxt.grey  = (wb_nxt >= 16'(PCT_ONE));
    if (in_alpha_in < 0) side_nxt.alpha = '0;
    else if (in_alpha_in > 16'sd4096) side_nxt.alpha = 13'd4096;
    else side_nxt.alpha = in_alpha_in[12:0];
    side_nxt.rb0 = rgb_byte(in_first_arg);
    side_nxt.rb1 = rgb_byte(in_second_arg);
    side_nxt.rb2 = rgb_byte(in_third_arg);
  end

  always_ff @(posedge clk) begin
    side_r[0] <= side_nxt;
    c1_r[0]   <= c1_nxt;
    c2_r[0]   <= c2_nxt;
    c3_r[0]   <= c3_nxt;
    // floor(a / 2048) biased into 44..8235
    u_r       <= {in_first_arg[23], in_first_arg[23:11]} + 14'd4140;
    lo11_r    <= in_first_arg[10:0];
    // 1 - |2l - 1| in percent units
    cbase_r   <= (c3_nxt < 15'd12800) ? 15'({c3_nxt, 1'b0})
                                      : 15'(17'd51200 - {1'b0, c3_nxt, 1'b0});
    gr_r[0]   <= 24'(c2_nxt) * 24'd255;
    gs_r[0]   <= wb_nxt;
    gq_r[0]   <= '0;
  end

  // Sideband and clamp carry
  always_ff @(posedge clk) begin
    for (int k = 1; k < 9; k++) begin
      side_r[k] <= side_r[k-1];
    end
    for (int k = 1; k < 5; k++) begin
      c1_r[k] <= c1_r[k-1];
      c2_r[k] <= c2_r[k-1];
      c3_r[k] <= c3_r[k-1];
    end
  end

  // Grey divider: one quotient bit per stage, MSB first
  always_ff @(posedge clk) begin
    for (int k = 1; k < 9; k++) begin
      logic [24:0] st;
      st = div_step(gr_r[k-1], gs_r[k-1], 8 - k);
      gr_r[k] <= st[23:0];
      gs_r[k] <= gs_r[k-1];
      gq_r[k] <= gq_r[k-1] | (8'(st[24]) << (8 - k));
    end
  end

  // Stage 2: quotient by 45, chroma product
  assign q45_prod = 28'(u_r) * 28'd11651;

  always_ff @(posedge clk) begin
    q45_r    <= q45_prod[26:19];
    u2_r     <= u_r;
    lo11_2_r <= lo11_r;
    cc_r[0]  <= 30'(cbase_r) * 30'(c2_r[0]);
  end

  // Stage 3: hue in 0..92159
  assign rem45 = u2_r - 14'(q45_r) * 14'd45;

  always_ff @(posedge clk) begin
    h_r     <= {rem45[5:0], lo11_2_r};
    cc_r[1] <= cc_r[0];
  end

  // Stage 4: sector and ramp factor
  always_comb begin
    if (h_r >= 17'd76800) sec_nxt = 3'd5;
    else if (h_r >= 17'd61440) sec_nxt = 3'd4;
    else if (h_r >= 17'd46080) sec_nxt = 3'd3;
    else if (h_r >= 17'd30720) sec_nxt = 3'd2;
    else if (h_r >= 17'd15360) sec_nxt = 3'd1;
    else sec_nxt = 3'd0;
    case (sec_nxt[2:1])
      2'd0:    hm = h_r[14:0];
      2'd1:    hm = 15'(h_r - 17'd30720);
      default: hm = 15'(h_r - 17'd61440);
    endcase
    x_nxt = (hm >= 15'd15360) ? 14'(15'd30720 - hm) : hm[13:0];
  end

  always_ff @(posedge clk) begin
    sec_r[0] <= sec_nxt;
    x_r      <= x_nxt;
    cc_r[2]  <= cc_r[1];
  end

  // Stage 5: sector terms and offset, hsl or hwb
  always_comb begin
    base  = 16'(PCT_ONE) - 16'(c2_r[3]) - 16'(c3_r[3]);
    mul_a = (side_r[3].op == OP_HSL) ? cc_r[2] : 30'(base);
    pb_nxt = 44'(mul_a) * 44'(x_r);
    pa_nxt = 44'(mul_a) * 44'(SECTOR);
    if (side_r[3].op == OP_HSL) begin
      pm_nxt = 44'(c3_r[3]) * 44'd393216000 - 44'(cc_r[2]) * 44'd7680;
    end else begin
      pm_nxt = 44'(c2_r[3]) * 44'(SECTOR);
    end
  end

  always_ff @(posedge clk) begin
    pa_r     <= pa_nxt;
    pb_r     <= pb_nxt;
    pm_r     <= pm_nxt;
    sec_r[1] <= sec_r[0];
  end

  // Stage 6: place terms by sector, add offset; rgb passes the clamped values through
  always_comb begin
    case (sec_r[1])
      3'd0:    begin plc[0] = pa_r; plc[1] = pb_r; plc[2] = '0;   end
      3'd1:    begin plc[0] = pb_r; plc[1] = pa_r; plc[2] = '0;   end
      3'd2:    begin plc[0] = '0;   plc[1] = pa_r; plc[2] = pb_r; end
      3'd3:    begin plc[0] = '0;   plc[1] = pb_r; plc[2] = pa_r; end
      3'd4:    begin plc[0] = pb_r; plc[1] = '0;   plc[2] = pa_r; end
      default: begin plc[0] = pa_r; plc[1] = '0;   plc[2] = pb_r; end
    endcase
    if (side_r[4].op == OP_RGB) begin
      n_nxt[0] = 44'(c1_r[4]);
      n_nxt[1] = 44'(c2_r[4]);
      n_nxt[2] = 44'(c3_r[4]);
    end else begin
      for (int k = 0; k < 3; k++) begin
        n_nxt[k] = plc[k] + pm_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      n_r[k] <= n_nxt[k];
    end
  end

  // Stages 7 to 9: scale, divide, round
  always_comb begin
    case (side_r[5].op)
      OP_HSL:  sel = SCL_HSL;
      OP_HWB:  sel = SCL_HWB;
      default: sel = SCL_RGB;
    endcase
  end

  for (genvar g = 0; g < 3; g++) begin : g_chan
    cssc_chan u_chan (
      .clk    (clk),
      .n      (n_r[g]),
      .sel    (sel),
      .byte_o (chan_byte[g])
    );
  end

  // Stage 10: grey rounding and final select
  always_comb begin
    gup = (25'({gr_r[8], 1'b0}) > 25'(gs_r[8]))
          || ((25'({gr_r[8], 1'b0}) == 25'(gs_r[8])) && gq_r[8][0]);
    gbyte = gq_r[8] + 8'(gup);
    red_nxt   = '0;
    green_nxt = '0;
    blue_nxt  = '0;
    case (side_r[8].op)
      OP_RGB: begin
        if (side_r[8].pct) begin
          red_nxt   = chan_byte[0];
          green_nxt = chan_byte[1];
          blue_nxt  = chan_byte[2];
        end else begin
          red_nxt   = side_r[8].rb0;
          green_nxt = side_r[8].rb1;
          blue_nxt  = side_r[8].rb2;
        end
      end
      OP_HSL: begin
        red_nxt   = chan_byte[0];
        green_nxt = chan_byte[1];
        blue_nxt  = chan_byte[2];
      end
      OP_HWB: begin
        if (side_r[8].grey) begin
          red_nxt   = gbyte;
          green_nxt = gbyte;
          blue_nxt  = gbyte;
        end else begin
          red_nxt   = chan_byte[0];
          green_nxt = chan_byte[1];
          blue_nxt  = chan_byte[2];
        end
      end
      default: begin
        red_nxt   = '0;
        green_nxt = '0;
        blue_nxt  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    red_r   <= red_nxt;
    green_r <= green_nxt;
    blue_r  <= blue_nxt;
    alpha_r <= side_r[8].alpha;
  end

  assign out_strobe     = vld_r[NUM_STAGES-1];
  assign out_red_byte   = red_r;
  assign out_green_byte = green_r;
  assign out_blue_byte  = blue_r;
  assign out_alpha_out  = alpha_r;

endmodule

// ----- rtl/cssc_chan.sv -----
// One channel back end: byte = round_half_even(17 * scaled(n) / (625 * 2^30)).
module cssc_chan (
  input  logic                clk,
  input  logic [43:0]         n,
  input  cssc_pkg::scale_t    sel,
  output logic [7:0]          byte_o
);
  import cssc_pkg::*;

  logic [47:0] prod;
  logic [17:0] t_r, t2_r;
  logic [29:0] lo_r, lo2_r;
  logic [35:0] qprod;
  logic [7:0]  qd_r;
  logic [17:0] rem_full;
  logic [9:0]  r2;
  logic        up;
  logic [7:0]  byte_r;

  // Stage A: fold 255/D into a per-mode constant
  always_comb begin
    case (sel)
      SCL_HSL: prod = 48'(n) * 48'd17;
      SCL_HWB: prod = 48'(n) * 48'd435200;
      SCL_RGB: prod = 48'(n) * 48'd6684672000;
      default: prod = '0;
    endcase
  end

  // Stage B: quotient by 625 via reciprocal
  assign qprod = 36'(t_r) * 36'd214749;

  // Stage C: remainder and round half to even
  always_comb begin
    rem_full = t2_r - 18'(qd_r) * 18'd625;
    r2 = rem_full[9:0];
    if (r2 > 10'd312) begin
      up = 1'b1;
    end else if (r2 == 10'd312) begin
      up = (lo2_r > 30'h2000_0000) || ((lo2_r == 30'h2000_0000) && qd_r[0]);
    end else begin
      up = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    t_r    <= prod[47:30];
    lo_r   <= prod[29:0];
    t2_r   <= t_r;
    lo2_r  <= lo_r;
    qd_r   <= qprod[34:27];
    byte_r <= qd_r + 8'(up);
  end

  assign byte_o = byte_r;

endmodule

// ----- rtl/cssc_chk.sv -----
// Port-level checks for the converter, bound to the top level.
module cssc_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic signed [15:0] in_alpha_in,
  input logic               out_strobe,
  input logic [12:0]        out_alpha_out
);

  // Block never stalls the sender
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  // Every accepted item yields a result strobe
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##10 out_strobe)
    else $error("result missing");

  // No result without a matching item
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start, 10))
    else $error("spurious result");

  // Alpha is the clamped input alpha of the same item
  a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (($past(in_alpha_in, 10) < 0 && out_alpha_out == 13'd0)
                 || ($past(in_alpha_in, 10) > 16'sd4096 && out_alpha_out == 13'd4096)
                 || ($past(in_alpha_in, 10) >= 0 && $past(in_alpha_in, 10) <= 16'sd4096
                     && out_alpha_out == $past(in_alpha_in[12:0], 10))))
    else $error("alpha mismatch");

endmodule

bind css_color_to_rgb_converter_top cssc_chk u_cssc_chk (.*);
